FILE: rtl/rdp_pkg.sv
// shared types and constants for the rotary dial pulse decoder
`timescale 1ns / 1ps

package rdp_pkg;

  // widths of the item fields and the threshold register
  localparam int RDP_THR_W   = 8;
  localparam int RDP_CNT_W   = 4;
  localparam int RDP_DIGIT_W = 5;
  localparam int RDP_TDATA_W = 8;

  localparam logic [RDP_THR_W-1:0] RDP_THRESHOLD_RESET = 8'd5;
  localparam logic [RDP_CNT_W-1:0] RDP_PULSE_MAX       = 4'd15;

  // dial phase; the unused code is handled as idle
  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_AWAIT_HIGH = 2'd1,
    PH_AWAIT_LOW  = 2'd2
  } rdp_phase_t;

  // one debounce test outcome
  typedef struct packed {
    logic                 fire;
    logic [RDP_THR_W-1:0] count;
  } rdp_deb_t;

  // result of one tick, as handed from the dial machine to the output stage
  typedef struct packed {
    rdp_phase_t                    phase;
    logic signed [RDP_DIGIT_W-1:0] digit;
    logic                          digit_valid;
  } rdp_result_t;

endpackage

FILE: rtl/rdp_dial_fsm.sv
// dial phase machine with debounce counters and pulse count
`timescale 1ns / 1ps

module rdp_dial_fsm
  import rdp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 enable_level,
  input  logic                 pulse_level,
  input  logic [RDP_THR_W-1:0] threshold,
  output rdp_result_t          result
);

  rdp_phase_t           phase;
  rdp_phase_t           phase_next;
  logic [RDP_CNT_W-1:0] pulse_count;
  logic [RDP_CNT_W-1:0] pulse_count_next;
  logic [RDP_THR_W-1:0] line_cnt;
  logic [RDP_THR_W-1:0] line_cnt_next;
  logic [RDP_THR_W-1:0] ret_cnt;
  logic [RDP_THR_W-1:0] ret_cnt_next;

  logic                 counting;
  logic                 line_match;
  logic [RDP_THR_W-1:0] ret_base;
  rdp_deb_t             line_test;
  rdp_deb_t             ret_test;

  // fires when the old count has reached the threshold; otherwise counts up or clears
  function automatic rdp_deb_t debounce(input logic match,
                                        input logic [RDP_THR_W-1:0] count,
                                        input logic [RDP_THR_W-1:0] thr);
    rdp_deb_t r;
    r.fire  = 1'b0;
    r.count = '0;
    if (match) begin
      if (count >= thr) begin
        r.fire = 1'b1;
      end else begin
        r.count = count + RDP_THR_W'(1);
      end
    end
    return r;
  endfunction

  // debounce tests: line test first, a firing line test clears the return count
  always_comb begin
    counting   = (phase == PH_AWAIT_HIGH) || (phase == PH_AWAIT_LOW);
    line_match = counting ? (pulse_level == (phase == PH_AWAIT_HIGH)) : !enable_level;
    line_test  = debounce(line_match, line_cnt, threshold);
    ret_base   = (counting && line_test.fire) ? '0 : ret_cnt;
    ret_test   = debounce(enable_level, ret_base, threshold);
  end

  // next state
  always_comb begin
    phase_next       = phase;
    pulse_count_next = pulse_count;
    line_cnt_next    = line_test.count;
    ret_cnt_next     = ret_cnt;
    unique case (phase)
      PH_AWAIT_HIGH: begin
        if (line_test.fire) begin
          phase_next = PH_AWAIT_LOW;
          if (pulse_count != RDP_PULSE_MAX) begin
            pulse_count_next = pulse_count + RDP_CNT_W'(1);
          end
        end
        ret_cnt_next = ret_test.count;
        if (ret_test.fire) begin
          phase_next = PH_IDLE;
        end
      end
      PH_AWAIT_LOW: begin
        if (line_test.fire) begin
          phase_next = PH_AWAIT_HIGH;
        end
        ret_cnt_next = ret_test.count;
        if (ret_test.fire) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        pulse_count_next = '0;
        if (line_test.fire) begin
          phase_next   = PH_AWAIT_HIGH;
          ret_cnt_next = '0;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    endcase
  end

  // result of this tick
  always_comb begin
    result.phase       = phase_next;
    result.digit_valid = counting && ret_test.fire;
    if (result.digit_valid) begin
      result.digit = $signed(RDP_DIGIT_W'({1'b0, pulse_count_next}) - RDP_DIGIT_W'(1));
    end else begin
      result.digit = '0;
    end
  end

  // state registers advance once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      pulse_count <= '0;
      line_cnt    <= '0;
      ret_cnt     <= '0;
    end else if (step) begin
      phase       <= phase_next;
      pulse_count <= pulse_count_next;
      line_cnt    <= line_cnt_next;
      ret_cnt     <= ret_cnt_next;
    end
  end

endmodule

FILE: rtl/rotary_dial_pulse_decoder.sv
// top level of the rotary dial pulse decoder: input stage, dial machine, output stage
`timescale 1ns / 1ps

// Each input item is one sample tick of the dial enable and pulse lines; each tick
// gives exactly one result item with digit_valid, digit (pulses minus one, signed)
// and the phase after the tick. A line event fires once the line has matched its
// target level for more than the configured threshold of ticks in a row. The block
// takes one item per clock cycle while the output is not stalled; an item passes an
// input register and the dial machine and comes out of the output register, and both
// registers keep moving while the downstream side takes results. Write the threshold
// only while no item is in flight.

module rotary_dial_pulse_decoder
  import rdp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [RDP_THR_W-1:0]   cfg_wr_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [RDP_TDATA_W-1:0] s_axis_tdata,  // [0] enable_level, [1] pulse_level
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [RDP_TDATA_W-1:0] m_axis_tdata   // [0] digit_valid, [5:1] digit, [7:6] phase
);

  logic [RDP_THR_W-1:0] threshold;
  logic                 in_valid;
  logic                 in_enable;
  logic                 in_pulse;
  logic                 advance;
  logic                 out_load;
  rdp_result_t          step_res;
  rdp_result_t          out_res;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= RDP_THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  // handshake: the input register moves whenever the output register can take its item
  assign out_load      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_load;
  assign s_axis_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_enable <= s_axis_tdata[0];
      in_pulse  <= s_axis_tdata[1];
    end
  end

  rdp_dial_fsm u_fsm (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .enable_level (in_enable),
    .pulse_level  (in_pulse),
    .threshold    (threshold),
    .result       (step_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tdata = {out_res.phase, out_res.digit, out_res.digit_valid};

endmodule

FILE: rtl/rdp_checker.sv
// port-level checks for the rotary dial pulse decoder
`timescale 1ns / 1ps

module rdp_checker
  import rdp_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [RDP_TDATA_W-1:0] m_axis_tdata
);

  // no result right after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a reported digit always comes with the return to idle
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[7:6] == 2'd0))
    else $error("digit reported outside idle");

  // without a report the digit field is zero
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[5:1] == 5'd0))
    else $error("digit field set without report");

  // the unused phase code never shows
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:6] != 2'd3))
    else $error("unused phase code on output");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind rotary_dial_pulse_decoder rdp_checker u_rdp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
